// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the atomic memory unit.
// The macros expect signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ----- src/amu_pkg.sv -----
// Package for the atomic memory unit: sizes, opcodes, state type and helpers.
// No dependencies; the interfaces and the atomic memory unit import it.
package amu_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int TAG_SHIFT   = 3;
    localparam int RES_ENTRIES = 8;

    localparam int DATA_W      = 64;
    localparam int OPCODE_W    = 4;
    localparam int BYTE_ADDR_W = 16;
    localparam int SIZE_W      = 2;

    localparam int WORD_ADDR_W = ADDR_BITS - 3;
    localparam int MEM_DEPTH   = 2 ** WORD_ADDR_W;
    localparam int TAG_W       = (ADDR_BITS > TAG_SHIFT) ? (ADDR_BITS - TAG_SHIFT) : 1;
    localparam int RES_IDX_W   = (RES_ENTRIES > 1) ? $clog2(RES_ENTRIES) : 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 4'd0,
        OP_STORE = 4'd1,
        OP_LR    = 4'd2,
        OP_SC    = 4'd3,
        OP_SWAP  = 4'd4,
        OP_ADD   = 4'd5,
        OP_SUB   = 4'd6,
        OP_AND   = 4'd7,
        OP_OR    = 4'd8,
        OP_XOR   = 4'd9,
        OP_MAX   = 4'd10,
        OP_MAXU  = 4'd11,
        OP_MIN   = 4'd12,
        OP_MINU  = 4'd13
    } amu_op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } amu_state_t;

    localparam logic [SIZE_W-1:0] SIZE_B = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_H = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_W4 = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_D = 2'd3;

    // Lane mask for an access of the given size.
    function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] m;
        begin
            unique case (size)
                SIZE_B:  m = 64'h0000_0000_0000_00FF;
                SIZE_H:  m = 64'h0000_0000_0000_FFFF;
                SIZE_W4: m = 64'h0000_0000_FFFF_FFFF;
                default: m = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    // Sign bit position of an access of the given size.
    function automatic logic [DATA_W-1:0] size_sign(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] s;
        begin
            unique case (size)
                SIZE_B:  s = 64'h0000_0000_0000_0080;
                SIZE_H:  s = 64'h0000_0000_0000_8000;
                SIZE_W4: s = 64'h0000_0000_8000_0000;
                default: s = 64'h8000_0000_0000_0000;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- src/amu_req_if.sv -----
// Request channel of the atomic memory unit: valid/ready and one access.
// Depends on amu_pkg for the field widths.
interface amu_req_if import amu_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [BYTE_ADDR_W-1:0] byte_address;
    logic [SIZE_W-1:0]      size_code;
    logic [DATA_W-1:0]      write_data;

    modport source (output valid, output opcode, output byte_address,
                    output size_code, output write_data, input ready);
    modport sink   (input valid, input opcode, input byte_address,
                    input size_code, input write_data, output ready);
endinterface

// ----- src/amu_rsp_if.sv -----
// Response channel of the atomic memory unit: valid/ready and read data.
// Depends on amu_pkg for the data width.
interface amu_rsp_if import amu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

// ----- src/amu_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module amu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/atomic_memory_unit_lr_sc_amo.sv -----
// Atomic memory unit with load-reserved, store-conditional and AMOs over a
// word-wide data RAM. The RAM read is issued in the cycle the request is
// accepted. The following cycle computes the new word, writes it back for
// stores, successful SCs and AMOs, and loads the response register; the state
// returns to idle in the cycle after that. A new request is accepted only once
// the previous response has been taken, at the latest in the accepting cycle
// itself, so a stalled response stalls the request side. After reset the RAM
// is zeroed one word per cycle, all 2^(ADDR_BITS-3) words (8192 at the default
// size), with req.ready low.
// Depends on amu_pkg, amu_req_if, amu_rsp_if, amu_ram and assert_macros.svh.
`include "assert_macros.svh"

module atomic_memory_unit_lr_sc_amo import amu_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    amu_req_if.sink   req,
    amu_rsp_if.source rsp
);

    amu_state_t              state_reg, state_next;
    logic [WORD_ADDR_W-1:0]  clr_addr_reg, clr_addr_next;

    logic [OPCODE_W-1:0]     op_reg;
    logic [SIZE_W-1:0]       size_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [DATA_W-1:0]       wdata_reg;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0]       rsp_data_reg, rsp_data_next;

    logic [TAG_W-1:0]        res_tag_reg [RES_ENTRIES];
    logic [RES_ENTRIES-1:0]  res_valid_reg, res_valid_next;
    logic [RES_IDX_W-1:0]    ptr_reg, ptr_next;
    logic                    tag_we;
    logic [RES_IDX_W-1:0]    tag_widx;

    logic                    accept;
    logic [ADDR_BITS-1:0]    addr_in;
    logic [ADDR_BITS-1:0]    addr_aligned;

    logic                    ram_we;
    logic [WORD_ADDR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic [DATA_W-1:0]       ram_rdata;

    logic [5:0]              byte_sh;
    logic [DATA_W-1:0]       mask;
    logic [DATA_W-1:0]       sbit;
    logic [DATA_W-1:0]       old_val;
    logic [DATA_W-1:0]       new_val;
    logic [DATA_W-1:0]       merged;
    logic [TAG_W-1:0]        tag_cur;
    logic [RES_ENTRIES-1:0]  match;
    logic                    hit;
    logic                    any_free;
    logic [RES_IDX_W-1:0]    free_idx;

    // Request side
    assign req.ready    = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept       = req.valid && req.ready;
    assign addr_in      = ADDR_BITS'(req.byte_address);
    assign addr_aligned = addr_in & ({ADDR_BITS{1'b1}} << req.size_code);

    amu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (addr_aligned[ADDR_BITS-1:3]),
        .rdata (ram_rdata)
    );

    // Lane extraction and operation
    always_comb
    begin
        byte_sh = {addr_reg[2:0], 3'b000};
        mask    = size_mask(size_reg);
        sbit    = size_sign(size_reg);
        old_val = (ram_rdata >> byte_sh) & mask;
        tag_cur = TAG_W'(addr_reg >> TAG_SHIFT);

        unique case (op_reg)
            OP_ADD:  new_val = old_val + wdata_reg;
            OP_SUB:  new_val = old_val - wdata_reg;
            OP_AND:  new_val = old_val & wdata_reg;
            OP_OR:   new_val = old_val | wdata_reg;
            OP_XOR:  new_val = old_val ^ wdata_reg;
            OP_MAX:  new_val = ((old_val ^ sbit) > (wdata_reg ^ sbit)) ? old_val : wdata_reg;
            OP_MAXU: new_val = (old_val > wdata_reg) ? old_val : wdata_reg;
            OP_MIN:  new_val = ((old_val ^ sbit) < (wdata_reg ^ sbit)) ? old_val : wdata_reg;
            OP_MINU: new_val = (old_val < wdata_reg) ? old_val : wdata_reg;
            default: new_val = wdata_reg;
        endcase

        merged = (ram_rdata & ~(mask << byte_sh)) | ((new_val & mask) << byte_sh);
    end

    // Reservation lookup: each entry compared in parallel
    always_comb
    begin
        match    = '0;
        any_free = 1'b0;
        free_idx = '0;
        for (int i = 0; i < RES_ENTRIES; i++)
        begin
            match[i] = res_valid_reg[i] && (res_tag_reg[i] == tag_cur);
        end
        for (int i = RES_ENTRIES - 1; i >= 0; i--)
        begin
            if (!res_valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = RES_IDX_W'(i);
            end
        end
        hit = |match;
    end

    // Sequencer: next state, RAM write port, tags and response
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg[ADDR_BITS-1:3];
        ram_wdata      = merged;
        res_valid_next = res_valid_reg;
        ptr_next       = ptr_reg;
        tag_we         = 1'b0;
        tag_widx       = free_idx;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {WORD_ADDR_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b1;
                rsp_data_next  = '0;
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        rsp_data_next = old_val;
                    end
                    OP_STORE:
                    begin
                        ram_we         = 1'b1;
                        res_valid_next = res_valid_reg & ~match;
                    end
                    OP_LR:
                    begin
                        rsp_data_next = old_val;
                        if (!hit)
                        begin
                            tag_we = 1'b1;
                            if (any_free)
                            begin
                                tag_widx = free_idx;
                            end
                            else
                            begin
                                tag_widx = ptr_reg;
                                ptr_next = (ptr_reg == RES_IDX_W'(RES_ENTRIES - 1)) ?
                                           '0 : ptr_reg + 1'b1;
                            end
                            res_valid_next[tag_widx] = 1'b1;
                        end
                    end
                    OP_SC:
                    begin
                        if (hit)
                        begin
                            ram_we         = 1'b1;
                            res_valid_next = res_valid_reg & ~match;
                        end
                        else
                        begin
                            rsp_data_next = DATA_W'(1);
                        end
                    end
                    OP_SWAP, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
                    OP_MAX, OP_MAXU, OP_MIN, OP_MINU:
                    begin
                        ram_we        = 1'b1;
                        rsp_data_next = old_val;
                    end
                    default:
                    begin
                        // undefined opcodes: no RAM or reservation change, zero response
                    end
                endcase
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            res_valid_reg <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            res_valid_reg <= res_valid_next;
            ptr_reg       <= ptr_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.opcode;
            size_reg  <= req.size_code;
            addr_reg  <= addr_aligned;
            wdata_reg <= req.write_data & size_mask(req.size_code);
        end
        if (tag_we)
        begin
            res_tag_reg[tag_widx] <= tag_cur;
        end
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

    `ASSERT_IMPLIES(a_exec_follows_accept, state_reg == ST_EXEC, $past(accept),
                    "execute cycle without an accepted beat")
    `ASSERT_CLK(a_rsp_two_cycles, accept |-> ##2 rsp.valid,
                "no response two cycles after accept")
    `ASSERT_CLK(a_ptr_moves_when_full, (ptr_reg != $past(ptr_reg)) |-> $past(&res_valid_reg),
                "replace pointer moved with a free entry")
    `ASSERT_IMPLIES(a_no_write_idle, ram_we, state_reg != ST_IDLE, "RAM written while idle")

endmodule
